/* hdl/pcaw_pkg.sv */
// ----------------------------------------------------------------------------
// pcaw_pkg
// Shared types, constants and helpers for the anti-windup PID controller.
// ----------------------------------------------------------------------------
package pcaw_pkg;

    localparam int SPEED_W  = 24;   // Q16.8 speeds, errors, integral, drive
    localparam int GAIN_W   = 16;   // Q4.12 gains
    localparam int LIM_W    = 23;   // unsigned Q15.8 limits
    localparam int FRAC_G   = 12;   // fraction bits of a gain
    localparam int WIDE_W   = SPEED_W + 1;
    localparam int PROD_W   = GAIN_W + SPEED_W;        // gain * error
    localparam int PRODD_W  = GAIN_W + WIDE_W;         // gain * derivative
    localparam int TERM_W   = PROD_W - FRAC_G;         // rounded P and I terms
    localparam int TERMD_W  = PRODD_W - FRAC_G;        // rounded D term
    localparam int SUM_W    = TERMD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SPEED_W;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT       = 3'd0,
        CFG_GAIN_P         = 3'd1,
        CFG_GAIN_I         = 3'd2,
        CFG_GAIN_D         = 3'd3,
        CFG_ERROR_LIMIT    = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5,
        CFG_OUTPUT_LIMIT   = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        SAT_NONE  = 2'd0,
        SAT_UPPER = 2'd1,
        SAT_LOWER = 2'd2
    } t_sat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PREP,
        BK_MUL,
        BK_SUM
    } t_back_state;

    typedef struct packed {
        logic signed [SPEED_W-1:0] setpoint;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [LIM_W-1:0]          error_limit;
        logic [LIM_W-1:0]          integral_limit;
        logic [LIM_W-1:0]          output_limit;
    } t_cfg;

    // One classified item as it waits between front and back.
    typedef struct packed {
        logic                      clr;
        logic signed [SPEED_W-1:0] err;
    } t_item;

    localparam logic signed [SPEED_W-1:0] SETPOINT_RST = 24'sd0;
    localparam logic signed [GAIN_W-1:0]  GAIN_P_RST   = 16'sd2458;
    localparam logic signed [GAIN_W-1:0]  GAIN_I_RST   = 16'sd2048;
    localparam logic signed [GAIN_W-1:0]  GAIN_D_RST   = 16'sd410;
    localparam logic [LIM_W-1:0]          ERR_LIM_RST  = 23'd204800;
    localparam logic [LIM_W-1:0]          INT_LIM_RST  = 23'd768000;
    localparam logic [LIM_W-1:0]          OUT_LIM_RST  = 23'd248320;

    // Symmetric clamp of a wide value to +/- lim; the result fits the speed width.
    function automatic logic signed [SPEED_W-1:0] clamp_sym(
        input logic signed [WIDE_W-1:0] x,
        input logic [LIM_W-1:0]         lim
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] r;
        hi = $signed({{(WIDE_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (x > hi) begin
            r = hi;
        end else if (x < lo) begin
            r = lo;
        end else begin
            r = x;
        end
        return r[SPEED_W-1:0];
    endfunction

endpackage

/* hdl/pid_controller_conditional_antiwindup.sv */
// ----------------------------------------------------------------------------
// pid_controller_conditional_antiwindup
// Items pass through the front register, the queue and the back-end sequencer,
// whose derivative, multiply and sum steps must commit the integral before the
// next item may read it; the sum step waits while the output register is full.
// Reset is synchronous and active low: it restores the register defaults,
// clears the integral and last error and empties the queue.
// ----------------------------------------------------------------------------
module pid_controller_conditional_antiwindup #(
    parameter int QUEUE_DEPTH = pcaw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write channel.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pcaw_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pcaw_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Sample channel.
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_req_type,
    input  logic signed [pcaw_pkg::SPEED_W-1:0]    i_measurement,
    // Result channel.
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [pcaw_pkg::SPEED_W-1:0]    o_drive,
    output logic [1:0]                             o_saturation
);
    import pcaw_pkg::*;

    // The block is split into a front end that takes items and works out the
    // clamped error, which needs no controller state, and a back end that owns
    // the integral and last error. A short queue between the two lets the front
    // keep accepting while the back is busy or its output register is full.

    t_cfg  r_cfg;
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_item w_front_item;
    t_item w_queue_item;

    // Configuration registers. The user must make writes only while the block is
    // idle; the block does not enforce this, and the port is always ready. An index past the last register is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint       <= SETPOINT_RST;
            r_cfg.gain_p         <= GAIN_P_RST;
            r_cfg.gain_i         <= GAIN_I_RST;
            r_cfg.gain_d         <= GAIN_D_RST;
            r_cfg.error_limit    <= ERR_LIM_RST;
            r_cfg.integral_limit <= INT_LIM_RST;
            r_cfg.output_limit   <= OUT_LIM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SETPOINT: begin
                    r_cfg.setpoint <= i_cfg_data;
                end
                CFG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_ERROR_LIMIT: begin
                    r_cfg.error_limit <= i_cfg_data[LIM_W-1:0];
                end
                CFG_INTEGRAL_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg_data[LIM_W-1:0];
                end
                CFG_OUTPUT_LIMIT: begin
                    r_cfg.output_limit <= i_cfg_data[LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: one register stage that classifies each item and clamps the
    // error to the error limit.
    pcaw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_measurement (i_measurement),
        .o_push        (w_push),
        .o_item        (w_front_item),
        .i_full        (w_full)
    );

    // Decoupling queue between front and back.
    pcaw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_queue_item)
    );

    // Back end: derivative and candidate integral, then the three gain products,
    // then the sum, the saturation decision and the conditional integral commit.
    // The finished item waits in an output register, so the back end may start
    // the next item while the result is still on offer.
    pcaw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_empty    (w_empty),
        .i_q_data     (w_queue_item),
        .o_q_pop      (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_drive      (o_drive),
        .o_saturation (o_saturation)
    );

endmodule

/* hdl/pcaw_queue.sv */
// ----------------------------------------------------------------------------
// pcaw_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module pcaw_queue #(
    parameter int DEPTH = pcaw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pcaw_pkg::t_item i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output pcaw_pkg::t_item o_data
);
    import pcaw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push)
        else $error("queue pushed while full");

endmodule

/* hdl/pcaw_front.sv */
// ----------------------------------------------------------------------------
// pcaw_front
// Accepts items, tells clear requests from samples and forms the clamped error.
// ----------------------------------------------------------------------------
module pcaw_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pcaw_pkg::t_cfg                         i_cfg,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_req_type,
    input  logic signed [pcaw_pkg::SPEED_W-1:0]    i_measurement,
    output logic                                   o_push,
    output pcaw_pkg::t_item                        o_item,
    input  logic                                   i_full
);
    import pcaw_pkg::*;

    logic                      r_valid;
    t_item                     r_item;
    t_item                     n_item;
    logic signed [WIDE_W-1:0]  w_diff;

    // The difference is taken one bit wider so that it never wraps.
    assign w_diff = $signed({i_cfg.setpoint[SPEED_W-1], i_cfg.setpoint})
                  - $signed({i_measurement[SPEED_W-1], i_measurement});

    always_comb begin
        n_item.clr = (i_req_type == REQ_CLEAR);
        if (i_req_type == REQ_CLEAR) begin
            n_item.err = '0;
        end else begin
            n_item.err = clamp_sym(w_diff, i_cfg.error_limit);
        end
    end

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

/* hdl/pcaw_back.sv */
// ----------------------------------------------------------------------------
// pcaw_back
// Three-step sequencer that forms the PID output, commits the state and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module pcaw_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pcaw_pkg::t_cfg                         i_cfg,
    input  logic                                   i_q_empty,
    input  pcaw_pkg::t_item                        i_q_data,
    output logic                                   o_q_pop,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [pcaw_pkg::SPEED_W-1:0]    o_drive,
    output logic [1:0]                             o_saturation
);
    import pcaw_pkg::*;

    t_back_state               r_state;
    t_back_state               n_state;
    logic                      w_finish;
    logic                      w_out_free;

    logic                      r_clr;
    logic signed [SPEED_W-1:0] r_err;
    logic signed [SPEED_W-1:0] r_last;
    logic signed [SPEED_W-1:0] r_integ;
    logic signed [WIDE_W-1:0]  r_deriv;
    logic signed [SPEED_W-1:0] r_cand;
    logic signed [TERM_W-1:0]  r_term_p;
    logic signed [TERM_W-1:0]  r_term_i;
    logic signed [TERMD_W-1:0] r_term_d;

    logic signed [PROD_W-1:0]  w_prod_p;
    logic signed [PROD_W-1:0]  w_prod_i;
    logic signed [PRODD_W-1:0] w_prod_d;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_olim;
    logic                      w_err_neg;
    logic                      w_err_pos;

    logic                      r_out_valid;
    logic signed [SPEED_W-1:0] r_drive;
    t_sat                      r_sat;

    assign w_out_free = !r_out_valid || i_ready;

    // Sequencer: pop, then derivative and candidate, then products, then sum.
    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = BK_PREP;
                end
            end
            BK_PREP: begin
                n_state = BK_MUL;
            end
            BK_MUL: begin
                n_state = BK_SUM;
            end
            BK_SUM: begin
                if (w_out_free) begin
                    w_finish = 1'b1;
                    if (!i_q_empty) begin
                        o_q_pop = 1'b1;
                        n_state = BK_PREP;
                    end else begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Products are Q20.20; dropping twelve bits of a signed value floors it.
    assign w_prod_p = $signed(i_cfg.gain_p) * r_err;
    assign w_prod_i = $signed(i_cfg.gain_i) * r_cand;
    assign w_prod_d = $signed(i_cfg.gain_d) * r_deriv;

    assign w_sum  = SUM_W'(r_term_p) + SUM_W'(r_term_i) + SUM_W'(r_term_d);
    assign w_olim = $signed({{(SUM_W-LIM_W){1'b0}}, i_cfg.output_limit});

    assign w_err_neg = r_err[SPEED_W-1];
    assign w_err_pos = !r_err[SPEED_W-1] && (r_err != '0);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_clr <= i_q_data.clr;
            r_err <= i_q_data.err;
        end
        if (r_state == BK_PREP) begin
            r_deriv <= $signed({r_err[SPEED_W-1], r_err})
                     - $signed({r_last[SPEED_W-1], r_last});
            r_cand  <= clamp_sym($signed({r_integ[SPEED_W-1], r_integ})
                                 + $signed({r_err[SPEED_W-1], r_err}),
                                 i_cfg.integral_limit);
        end
        if (r_state == BK_MUL) begin
            r_term_p <= w_prod_p[PROD_W-1:FRAC_G];
            r_term_i <= w_prod_i[PROD_W-1:FRAC_G];
            r_term_d <= w_prod_d[PRODD_W-1:FRAC_G];
        end
    end

    // Controller state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_integ     <= '0;
            r_drive     <= '0;
            r_sat       <= SAT_NONE;
        end else begin
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_finish) begin
                if (r_clr) begin
                    r_last  <= '0;
                    r_integ <= '0;
                    r_drive <= '0;
                    r_sat   <= SAT_NONE;
                end else begin
                    r_last <= r_err;
                    if (w_sum > w_olim) begin
                        r_drive <= w_olim[SPEED_W-1:0];
                        r_sat   <= SAT_UPPER;
                        if (w_err_neg) begin
                            r_integ <= r_cand;
                        end
                    end else if (w_sum < -w_olim) begin
                        r_drive <= -w_olim[SPEED_W-1:0];
                        r_sat   <= SAT_LOWER;
                        if (w_err_pos) begin
                            r_integ <= r_cand;
                        end
                    end else begin
                        r_drive <= w_sum[SPEED_W-1:0];
                        r_sat   <= SAT_NONE;
                        r_integ <= r_cand;
                    end
                end
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_drive      = r_drive;
    assign o_saturation = r_sat;

    a_upper_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sat == SAT_UPPER)
            |-> (r_drive == $signed({1'b0, i_cfg.output_limit})))
        else $error("upper clip does not sit on the output limit");

    a_lower_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sat == SAT_LOWER)
            |-> (r_drive == -$signed({1'b0, i_cfg.output_limit})))
        else $error("lower clip does not sit on the negative output limit");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == BK_IDLE || r_state == BK_SUM))
        else $error("item taken from the queue while the sequencer is busy");

endmodule
